[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros: shared assertion macros
// Clocked on clk, disabled while rst is high. Empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expression holds at every clock edge
`define ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(name, expr)
`define ASSERT_IMPL(name, ante, cons)
`define ASSERT_NEXT(name, ante, cons)

`endif

`endif

[hdl/rabs_pkg.sv]
// ----------------------------------------------------------------------------
// rabs_pkg: shared types for the rank assignment block
// Field widths, the token that travels down the cell chain, cell controls.
// ----------------------------------------------------------------------------
package rabs_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 7;

  // value in flight along the chain, with its count of smaller-or-earlier
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
    logic [RANK_W-1:0]         cnt;
  } token_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

[hdl/rabs_cell.sv]
// ----------------------------------------------------------------------------
// rabs_cell: one storage cell of the ranking chain
// Holds one value and its running count; compares each passing token.
// ----------------------------------------------------------------------------
module rabs_cell
  import rabs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  token_t            tok_in,
  output token_t            tok_out,
  input  logic [RANK_W-1:0] cnt_in,
  output logic [RANK_W-1:0] cnt_out
);

  logic                      occ;
  logic signed [VALUE_W-1:0] value;
  logic [RANK_W-1:0]         cnt;
  logic                      tok_less;

  // later token strictly below the stored value: stored cell gains one
  assign tok_less = $signed(tok_in.value) < $signed(value);
  assign cnt_out  = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ           <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid & occ;
      if (ctrl.clear) begin
        occ <= 1'b0;
      end else if (tok_in.valid && !occ) begin
        occ <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_out.value <= tok_in.value;
    // stored value is earlier, so equal counts against the token
    tok_out.cnt   <= tok_less ? tok_in.cnt : tok_in.cnt + RANK_W'(1);
    if (tok_in.valid && !occ) begin
      value <= tok_in.value;
    end
    if (ctrl.shift) begin
      cnt <= cnt_in;
    end else if (tok_in.valid) begin
      if (!occ) begin
        cnt <= tok_in.cnt;
      end else if (tok_less) begin
        cnt <= cnt + RANK_W'(1);
      end
    end
  end

endmodule

[hdl/rank_assign_by_selection.sv]
// ----------------------------------------------------------------------------
// rank_assign_by_selection: rank a set of signed values in load order
// Values travel down a chain of MAX_ITEMS cells, one cell per cycle.
// ----------------------------------------------------------------------------
// Values are taken one per cycle while loading. Each value enters a chain of
// MAX_ITEMS cells and moves one cell per clock until it reaches the first
// free cell, comparing against every stored value on the way, so the counts
// are complete once the chain has drained. After the transfer flagged
// is_last the block stops taking input while the last value walks to its
// cell, then delivers N ranks (N = stored elements) in load order, one per
// cycle while out_ready is high, shifted out of cell 0.
// Input is taken again after the result flagged end_of_set. Elements beyond
// MAX_ITEMS are dropped and every rank of that set carries overflow.
module rank_assign_by_selection
  import rabs_pkg::*;
#(
  parameter int MAX_ITEMS = 64
)
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      is_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [RANK_W-1:0]         rank,
  output logic                      end_of_set,
  output logic                      overflow
);

`include "assert_macros.svh"

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_SETTLE = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      filled;
  logic [CNT_W-1:0]      remain;
  logic                  ovf;
  logic                  single;
  token_t                tok [MAX_ITEMS+1];
  logic [RANK_W-1:0]     cnt_link [MAX_ITEMS+1];
  logic [MAX_ITEMS:0]    tok_valid;
  logic                  tok_busy;
  logic                  full;
  logic [CNT_W-1:0]      stored_n;
  logic                  in_xfer;
  logic                  out_xfer;
  cell_ctrl_t            ctrl;

  assign in_ready   = (state == ST_LOAD);
  assign out_valid  = (state == ST_EMIT);
  assign in_xfer    = in_valid & in_ready;
  assign out_xfer   = out_valid & out_ready;
  assign full       = (filled == CNT_W'(MAX_ITEMS));
  assign stored_n   = full ? filled : filled + CNT_W'(1);

  assign rank       = single ? '0 : cnt_link[0] + RANK_W'(1);
  assign end_of_set = (remain == CNT_W'(1));
  assign overflow   = ovf;

  assign ctrl.shift = out_xfer;
  assign ctrl.clear = out_xfer & end_of_set;

  assign cnt_link[MAX_ITEMS] = '0;

  always_comb begin
    for (int k = 0; k <= MAX_ITEMS; k++) begin
      tok_valid[k] = tok[k].valid;
    end
  end
  assign tok_busy = |tok_valid;

  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    rabs_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1]),
      .cnt_in  (cnt_link[k+1]),
      .cnt_out (cnt_link[k])
    );
  end

  // injection stage feeding cell 0
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else begin
      tok[0].valid <= in_xfer & ~full;
    end
  end

  always_ff @(posedge clk) begin
    tok[0].value <= value;
    tok[0].cnt   <= '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      filled <= '0;
      remain <= '0;
      ovf    <= 1'b0;
      single <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              filled <= filled + CNT_W'(1);
            end
            if (is_last) begin
              state  <= ST_SETTLE;
              remain <= stored_n;
              single <= (stored_n < CNT_W'(2));
            end
          end
        end
        ST_SETTLE: begin
          if (!tok_busy) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_xfer) begin
            remain <= remain - CNT_W'(1);
            if (end_of_set) begin
              state  <= ST_LOAD;
              filled <= '0;
              ovf    <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // a token always finds a free cell before running off the chain
  `ASSERT_ALWAYS(a_no_spill, !tok[MAX_ITEMS].valid)
  `ASSERT_IMPL(a_quiet_emit, state == ST_EMIT, !tok_busy && remain != '0)
  `ASSERT_NEXT(a_end_return, out_xfer && end_of_set, state == ST_LOAD && filled == '0)
  `ASSERT_ALWAYS(a_fill_bound, filled <= CNT_W'(MAX_ITEMS))

endmodule
